FILE: sv/eptm_pkg.sv
// ----------------------------------------------------------------------------
// eptm_pkg
// shared constants, types and the arctangent table for the pose matrix unit
// ----------------------------------------------------------------------------
package eptm_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS    = 30;
    localparam int TRIG_W          = 34;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [TRIG_W-1:0] trig_t;

    function automatic trig_t atan_lut(input logic [4:0] idx);
        trig_t v;
        case (idx)
            5'd0:  v = 34'sh020000000;
            5'd1:  v = 34'sh012E4051E;
            5'd2:  v = 34'sh009FB385B;
            5'd3:  v = 34'sh0051111D4;
            5'd4:  v = 34'sh0028B0D43;
            5'd5:  v = 34'sh00145D7E1;
            5'd6:  v = 34'sh000A2F61E;
            5'd7:  v = 34'sh000517C55;
            5'd8:  v = 34'sh00028BE53;
            5'd9:  v = 34'sh000145F2F;
            5'd10: v = 34'sh0000A2F98;
            5'd11: v = 34'sh0000517CC;
            5'd12: v = 34'sh000028BE6;
            5'd13: v = 34'sh0000145F3;
            5'd14: v = 34'sh00000A2FA;
            5'd15: v = 34'sh00000517D;
            5'd16: v = 34'sh0000028BE;
            5'd17: v = 34'sh00000145F;
            5'd18: v = 34'sh000000A30;
            5'd19: v = 34'sh000000518;
            5'd20: v = 34'sh00000028C;
            5'd21: v = 34'sh000000146;
            5'd22: v = 34'sh0000000A3;
            5'd23: v = 34'sh000000051;
            5'd24: v = 34'sh000000029;
            5'd25: v = 34'sh000000014;
            5'd26: v = 34'sh00000000A;
            5'd27: v = 34'sh000000005;
            5'd28: v = 34'sh000000003;
            5'd29: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round half up of a q4.30 product
    function automatic trig_t m30(input trig_t a, input trig_t b);
        logic signed [2*TRIG_W-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return p[TRIG_W+29:30];
    endfunction

endpackage

FILE: sv/eptm_cordic.sv
// ----------------------------------------------------------------------------
// eptm_cordic
// pipelined rotation-mode cordic, one stage per iteration, sine and cosine
// ----------------------------------------------------------------------------
module eptm_cordic
    import eptm_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic [ANGLE_WIDTH-1:0] angle,
    output trig_t                  cos_q,
    output trig_t                  sin_q
);

    localparam int N = CORDIC_STEPS;

    trig_t x_reg [N+1];
    trig_t y_reg [N+1];
    trig_t z_reg [N+1];
    logic  f_reg [N+1];

    logic [31:0] p0;
    logic [31:0] p1;
    logic        flip0;

    always_comb
    begin
        p0    = {angle, {(32-ANGLE_WIDTH){1'b0}}};
        flip0 = p0[31] ^ p0[30];
        p1    = flip0 ? (p0 - 32'h8000_0000) : p0;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= CORDIC_GAIN;
        y_reg[0] <= '0;
        z_reg[0] <= TRIG_W'(signed'(p1));
        f_reg[0] <= flip0;
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][TRIG_W-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_lut(5'(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_lut(5'(i));
            end
            f_reg[i+1] <= f_reg[i];
        end
    end

    assign cos_q = f_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_q = f_reg[N] ? -y_reg[N] : y_reg[N];

endmodule

FILE: sv/euler_pose_to_model_matrix_unit.sv
// ----------------------------------------------------------------------------
// euler_pose_to_model_matrix_unit
// pose (position, yaw/pitch/roll, scale) to twelve-entry affine model matrix
// ----------------------------------------------------------------------------
// One pose word enters per cycle and one matrix word leaves per cycle. Each
// word passes the 31-stage sine/cosine pipeline (input register plus 30
// iterations) and then five rotation and scale stages. busy is never raised;
// the receiver cannot stall and must take done words as they come.
module euler_pose_to_model_matrix_unit
    import eptm_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
    input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
    input  logic signed [COORD_WIDTH-1:0] scale_x,
    input  logic signed [COORD_WIDTH-1:0] scale_y,
    input  logic signed [COORD_WIDTH-1:0] scale_z,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] a00,
    output logic signed [COORD_WIDTH-1:0] a01,
    output logic signed [COORD_WIDTH-1:0] a02,
    output logic signed [COORD_WIDTH-1:0] a10,
    output logic signed [COORD_WIDTH-1:0] a11,
    output logic signed [COORD_WIDTH-1:0] a12,
    output logic signed [COORD_WIDTH-1:0] a20,
    output logic signed [COORD_WIDTH-1:0] a21,
    output logic signed [COORD_WIDTH-1:0] a22,
    output logic signed [COORD_WIDTH-1:0] trans_x,
    output logic signed [COORD_WIDTH-1:0] trans_y,
    output logic signed [COORD_WIDTH-1:0] trans_z
);

    localparam int CL  = CORDIC_STEPS + 1;
    localparam int LAT = CL + 5;
    localparam int CW  = COORD_WIDTH;
    localparam int PW  = TRIG_W + CW;

    typedef logic signed [CW-1:0] coord_t;

    trig_t cy, sy, cp, sp, cr, sr;

    eptm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw
        (.clk(clk), .angle(yaw_angle), .cos_q(cy), .sin_q(sy));
    eptm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch
        (.clk(clk), .angle(pitch_angle), .cos_q(cp), .sin_q(sp));
    eptm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll
        (.clk(clk), .angle(roll_angle), .cos_q(cr), .sin_q(sr));

    logic   vld_reg [LAT];
    coord_t px_reg [LAT];
    coord_t py_reg [LAT];
    coord_t pz_reg [LAT];
    coord_t sx_reg [LAT];
    coord_t sy_reg [LAT];
    coord_t sz_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg[0] <= pos_x;
        py_reg[0] <= pos_y;
        pz_reg[0] <= pos_z;
        sx_reg[0] <= scale_x;
        sy_reg[0] <= scale_y;
        sz_reg[0] <= scale_z;
        for (int k = 1; k < LAT; k++)
        begin
            px_reg[k] <= px_reg[k-1];
            py_reg[k] <= py_reg[k-1];
            pz_reg[k] <= pz_reg[k-1];
            sx_reg[k] <= sx_reg[k-1];
            sy_reg[k] <= sy_reg[k-1];
            sz_reg[k] <= sz_reg[k-1];
        end
    end

    // stage a: first level products
    trig_t crcy_reg, srcy_reg, crsy_reg, srsy_reg, srcp_reg, crcp_reg;
    trig_t srsp_reg, crsp_reg, cysp_reg, cycp_reg, nsy_reg, sp_a_reg, cp_a_reg;
    always_ff @(posedge clk)
    begin
        crcy_reg <= m30(cr, cy);
        srcy_reg <= m30(sr, cy);
        crsy_reg <= m30(cr, sy);
        srsy_reg <= m30(sr, sy);
        srcp_reg <= m30(sr, cp);
        crcp_reg <= m30(cr, cp);
        srsp_reg <= m30(sr, sp);
        crsp_reg <= m30(cr, sp);
        cysp_reg <= m30(cy, sp);
        cycp_reg <= m30(cy, cp);
        nsy_reg  <= -sy;
        sp_a_reg <= sp;
        cp_a_reg <= cp;
    end

    // stage b: second level products
    trig_t r_b_reg [9];
    trig_t t01_reg, t02_reg, t11_reg, t12_reg;
    trig_t u01_reg, u02_reg, u11_reg, u12_reg;
    always_ff @(posedge clk)
    begin
        t01_reg <= m30(crsy_reg, sp_a_reg);
        t02_reg <= m30(crsy_reg, cp_a_reg);
        t11_reg <= m30(srsy_reg, sp_a_reg);
        t12_reg <= m30(srsy_reg, cp_a_reg);
        u01_reg <= srcp_reg;
        u02_reg <= srsp_reg;
        u11_reg <= crcp_reg;
        u12_reg <= crsp_reg;
        r_b_reg[0] <= crcy_reg;
        r_b_reg[3] <= srcy_reg;
        r_b_reg[6] <= nsy_reg;
        r_b_reg[7] <= cysp_reg;
        r_b_reg[8] <= cycp_reg;
        r_b_reg[1] <= '0;
        r_b_reg[2] <= '0;
        r_b_reg[4] <= '0;
        r_b_reg[5] <= '0;
    end

    // stage c: rotation sums
    trig_t r_reg [9];
    always_ff @(posedge clk)
    begin
        r_reg[0] <= r_b_reg[0];
        r_reg[1] <= t01_reg - u01_reg;
        r_reg[2] <= u02_reg + t02_reg;
        r_reg[3] <= r_b_reg[3];
        r_reg[4] <= u11_reg + t11_reg;
        r_reg[5] <= t12_reg - u12_reg;
        r_reg[6] <= r_b_reg[6];
        r_reg[7] <= r_b_reg[7];
        r_reg[8] <= r_b_reg[8];
    end

    // stage d: scale products, stage e: round and saturate
    logic signed [PW-1:0] prod_reg [9];
    coord_t               a_reg [9];
    coord_t               sc [3];

    assign sc[0] = sx_reg[CL+2];
    assign sc[1] = sy_reg[CL+2];
    assign sc[2] = sz_reg[CL+2];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            prod_reg[k] <= PW'(r_reg[k]) * PW'(sc[k%3]);
    end

    function automatic coord_t sat_round(input logic signed [PW-1:0] p);
        logic signed [PW-30:0] q;
        logic signed [PW:0]    s;
        s = {p[PW-1], p} + (PW+1)'(1 <<< 29);
        q = s[PW:30];
        if (q > (PW-29)'(signed'({1'b0, {(CW-1){1'b1}}})))
            return {1'b0, {(CW-1){1'b1}}};
        else if (q < (PW-29)'(signed'({1'b1, {(CW-1){1'b0}}})))
            return {1'b1, {(CW-1){1'b0}}};
        else
            return q[CW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            a_reg[k] <= sat_round(prod_reg[k]);
    end

    assign busy    = 1'b0;
    assign done    = vld_reg[LAT-1];
    assign a00     = a_reg[0];
    assign a01     = a_reg[1];
    assign a02     = a_reg[2];
    assign a10     = a_reg[3];
    assign a11     = a_reg[4];
    assign a12     = a_reg[5];
    assign a20     = a_reg[6];
    assign a21     = a_reg[7];
    assign a22     = a_reg[8];
    assign trans_x = px_reg[LAT-1];
    assign trans_y = py_reg[LAT-1];
    assign trans_z = pz_reg[LAT-1];

endmodule

FILE: verif/euler_pose_to_model_matrix_unit_test.sv
// ----------------------------------------------------------------------------
// euler_pose_to_model_matrix_unit_test
// checks pose words against a bit-exact cordic/rotation/scale predictor:
// directed extremes and special angles, then random poses, mostly with random gaps
// ----------------------------------------------------------------------------
module euler_pose_to_model_matrix_unit_test;
    import eptm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 32;
    localparam int AW = 16;
    localparam int LATENCY = 36;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [AW-1:0] angle_t;

    typedef struct packed {
        coord_t px, py, pz;
        angle_t yaw, pitch, roll;
        coord_t sx, sy, sz;
    } pose_t;

    typedef struct packed {
        coord_t a00, a01, a02, a10, a11, a12, a20, a21, a22, tx, ty, tz;
    } matrix_t;

    logic   clk, rst_n, start, busy, done;
    coord_t pos_x, pos_y, pos_z, scale_x, scale_y, scale_z;
    angle_t yaw_angle, pitch_angle, roll_angle;
    coord_t a00, a01, a02, a10, a11, a12, a20, a21, a22, trans_x, trans_y, trans_z;

    matrix_t expected_matrices[$];
    int      errors;
    bit      no_gaps;

    euler_pose_to_model_matrix_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("** euler_pose_to_model_matrix_unit: FAILED **");
        $finish;
    end

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void sin_cos(angle_t a, output longint c, output longint s);
        logic [31:0] p;
        bit flip;
        longint x, y, z, xs, ys;
        p = {a, 16'h0};
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if ((p + 32'h4000_0000) & 32'h8000_0000)
        begin
            p = p - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(p));
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= longint'(atan_lut(i[4:0]));
            end
            else
            begin
                x += ys; y -= xs; z += longint'(atan_lut(i[4:0]));
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint mul30(longint a, longint b);
        return fshr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic coord_t scaled_entry(longint r, coord_t sc);
        longint s, sh, sl, v;
        s = longint'(sc);
        sh = fshr(s, 16);
        sl = s - sh * 65536;
        v = fshr(r * sh + fshr(r * sl + (64'sd1 <<< 29), 16), 14);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return coord_t'(v);
    endfunction

    function automatic matrix_t pose_matrix(pose_t p);
        longint cy, sy, cp, sp, cr, sr, crsy, srsy;
        longint r[9];
        coord_t sc[3];
        coord_t o[9];
        matrix_t m;
        sin_cos(p.yaw, cy, sy);
        sin_cos(p.pitch, cp, sp);
        sin_cos(p.roll, cr, sr);
        crsy = mul30(cr, sy);
        srsy = mul30(sr, sy);
        r[0] = mul30(cr, cy);
        r[1] = mul30(crsy, sp) - mul30(sr, cp);
        r[2] = mul30(sr, sp) + mul30(crsy, cp);
        r[3] = mul30(sr, cy);
        r[4] = mul30(cr, cp) + mul30(srsy, sp);
        r[5] = mul30(srsy, cp) - mul30(cr, sp);
        r[6] = -sy;
        r[7] = mul30(cy, sp);
        r[8] = mul30(cy, cp);
        sc[0] = p.sx; sc[1] = p.sy; sc[2] = p.sz;
        for (int i = 0; i < 9; i++)
            o[i] = scaled_entry(r[i], sc[i % 3]);
        m = '{o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8], p.px, p.py, p.pz};
        return m;
    endfunction

    // called and returning at a rising edge; start stays high for back to back words
    task automatic send_pose(pose_t p);
        while (!no_gaps && $urandom_range(99) < 33)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        pos_x       <= p.px;  pos_y <= p.py;  pos_z <= p.pz;
        yaw_angle   <= p.yaw; pitch_angle <= p.pitch; roll_angle <= p.roll;
        scale_x     <= p.sx;  scale_y <= p.sy; scale_z <= p.sz;
        expected_matrices.push_back(pose_matrix(p));
        do @(posedge clk); while (busy);
    endtask

    always @(posedge clk)
    begin
        matrix_t got, want;
        if (rst_n && done)
        begin
            got = '{a00, a01, a02, a10, a11, a12, a20, a21, a22, trans_x, trans_y, trans_z};
            if (expected_matrices.size() == 0)
            begin
                $display("%t unexpected word %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = expected_matrices.pop_front();
                for (int i = 0; i < 12; i++)
                    if (got[CW*(11-i) +: CW] !== want[CW*(11-i) +: CW])
                    begin
                        $display("%t entry %0d expected %h actual %h",
                                 $realtime, i, want[CW*(11-i) +: CW], got[CW*(11-i) +: CW]);
                        errors++;
                    end
            end
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000);
            1: return coord_t'($urandom_range(3) << 16) * ($urandom_range(1) ? 1 : -1);
            2: return coord_t'(32'(signed'($urandom_range(65535*8)) - 65536*4));
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic angle_t rand_angle();
        case ($urandom_range(4))
            0: return angle_t'($urandom_range(7) << 13);
            1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
            default: return angle_t'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        angle_t angs[10] = '{16'h0000, 16'h4000, 16'hc000, 16'h8000, 16'h7fff,
                             16'h8001, 16'h3fff, 16'h4001, 16'h0001, 16'hffff};
        pose_t p;
        for (int i = 0; i < 10; i++)
        begin
            p = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, angs[i], angs[(i+3)%10],
                  angs[(i+6)%10], 32'h0001_0000, 32'hffff_0000, 32'h0002_8000};
            send_pose(p);
        end
        for (int i = 0; i < 8; i++)
        begin
            p = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, angs[i], angs[i+1],
                  angs[i+2], (i[0] ? 32'h7fff_ffff : 32'h8000_0000),
                  (i[1] ? 32'h7fff_ffff : 32'h8000_0000),
                  (i[2] ? 32'h7fff_ffff : 32'h0000_0000)};
            send_pose(p);
        end
    endtask

    task automatic test_random();
        pose_t p;
        for (int i = 0; i < 650; i++)
        begin
            no_gaps = (i >= 200 && i < 300);
            p = '{rand_coord(), rand_coord(), rand_coord(), rand_angle(), rand_angle(),
                  rand_angle(), rand_coord(), rand_coord(), rand_coord()};
            send_pose(p);
        end
        no_gaps = 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_matrices.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        {pos_x, pos_y, pos_z, scale_x, scale_y, scale_z} = '0;
        {yaw_angle, pitch_angle, roll_angle} = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        drain();
        if (errors == 0)
            $display("** euler_pose_to_model_matrix_unit: PASSED **");
        else
            $display("** euler_pose_to_model_matrix_unit: FAILED **");
        $finish;
    end

endmodule
